// ----- rtl/pep8_instruction_stream_decoder_unit_assert.svh -----
// Assertion macros for the Pep/8 instruction stream decoder.
// Each macro expects signals named clk and rst_n in the scope that uses it.
`ifndef PEP8_INSTRUCTION_STREAM_DECODER_UNIT_ASSERT_SVH
`define PEP8_INSTRUCTION_STREAM_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define P8ISD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define P8ISD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/p8isd_pkg.sv -----
// Shared types, opcode boundaries and mnemonic numbers for the Pep/8 decoder.
// No dependencies; used by the framer, the field decoder and the top level.
package p8isd_pkg;

  localparam logic [7:0] OP_BR    = 8'h04;
  localparam logic [7:0] OP_NOTA  = 8'h18;
  localparam logic [7:0] OP_NOP0  = 8'h24;
  localparam logic [7:0] OP_NOP   = 8'h28;
  localparam logic [7:0] OP_CHARI = 8'h48;
  localparam logic [7:0] OP_RET0  = 8'h58;
  localparam logic [7:0] OP_ADDSP = 8'h60;
  localparam logic [7:0] OP_ADDA  = 8'h70;

  localparam logic [5:0] MN_BR    = 6'd4;
  localparam logic [5:0] MN_NOTA  = 6'd14;
  localparam logic [5:0] MN_NOP0  = 6'd26;
  localparam logic [5:0] MN_NOP   = 6'd30;
  localparam logic [5:0] MN_CHARI = 6'd34;
  localparam logic [5:0] MN_RET0  = 6'd36;
  localparam logic [5:0] MN_ADDSP = 6'd44;
  localparam logic [5:0] MN_ADDA  = 6'd46;

  typedef struct packed {
    logic        emit;
    logic [15:0] addr;
    logic [7:0]  op;
    logic [15:0] spec;
    logic        truncated;
  } frame_t;

  typedef struct packed {
    logic [15:0] inst_address;
    logic [7:0]  opcode;
    logic [5:0]  mnemonic_code;
    logic        register_select;
    logic [2:0]  addressing_mode;
    logic        one_bit_mode;
    logic [15:0] operand_spec;
    logic        is_unary;
    logic        status;
  } result_t;

  function automatic logic op_is_unary(input logic [7:0] op);
    return (op < OP_BR) || (op >= OP_NOTA && op < OP_NOP) ||
           (op >= OP_RET0 && op < OP_ADDSP);
  endfunction

endpackage

// ----- rtl/pep8_instruction_stream_decoder_unit.sv -----
// Pep/8 instruction stream decoder. Takes one program byte per beat and returns
// one beat per instruction with its address, opcode, mnemonic number, register
// bit, addressing mode and 16-bit operand specifier. A unary opcode yields its
// beat from that byte; any other opcode yields its beat with the second operand
// byte, or with status 1 if the image ends (last_byte) before then. The next
// byte after a last_byte starts a new image at address 0. The block accepts a
// byte every cycle unless in_stall is high; a result passes through the input
// register and then the result register before it is offered, and in_stall
// rises only while a result waits in the result register under out_stall.
// Depends on p8isd_pkg, p8isd_framer, p8isd_decode and the assertion header.
module pep8_instruction_stream_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_inst_address,
  output logic [7:0]  out_opcode,
  output logic [5:0]  out_mnemonic_code,
  output logic        out_register_select,
  output logic [2:0]  out_addressing_mode,
  output logic        out_one_bit_mode,
  output logic [15:0] out_operand_spec,
  output logic        out_is_unary,
  output logic        out_status
);
  import p8isd_pkg::*;

  logic    in_valid_r;
  logic    [7:0] byte_r;
  logic    last_r;
  logic    out_valid_r;
  result_t out_r;
  logic    out_free;
  logic    advance;
  logic    accept;
  frame_t  frame;
  result_t result;
  logic    unary_clean;
  logic    branch_clean;
  logic    held_blocked;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign accept   = in_valid && !in_stall;

  p8isd_framer u_framer (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .byte_value(byte_r),
    .last_byte (last_r),
    .frame     (frame)
  );

  p8isd_decode u_decode (
    .frame (frame),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (accept) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
    if (accept) begin
      byte_r <= in_byte_value;
      last_r <= in_last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && frame.emit;
    end
    if (out_free && advance && frame.emit) begin
      out_r <= result;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_inst_address    = out_r.inst_address;
  assign out_opcode          = out_r.opcode;
  assign out_mnemonic_code   = out_r.mnemonic_code;
  assign out_register_select = out_r.register_select;
  assign out_addressing_mode = out_r.addressing_mode;
  assign out_one_bit_mode    = out_r.one_bit_mode;
  assign out_operand_spec    = out_r.operand_spec;
  assign out_is_unary        = out_r.is_unary;
  assign out_status          = out_r.status;

  assign unary_clean  = (out_operand_spec == 16'd0) && (out_addressing_mode == 3'd0);
  assign branch_clean = !out_register_select && (out_addressing_mode[2:1] == 2'b00);
  assign held_blocked = out_valid && out_stall;

`include "pep8_instruction_stream_decoder_unit_assert.svh"

  `P8ISD_ASSERT_IMPL(a_trunc_not_unary, out_valid && out_status, !out_is_unary, "truncated unary")
  `P8ISD_ASSERT_IMPL(a_unary_no_operand, out_valid && out_is_unary, unary_clean, "unary operand")
  `P8ISD_ASSERT_IMPL(a_branch_no_reg, out_valid && out_one_bit_mode, branch_clean, "branch fields")
  `P8ISD_ASSERT_IMPL(a_stall_cause, in_stall, held_blocked, "stall without blocked result")
  `P8ISD_ASSERT_NEXT(a_held_result, held_blocked, out_valid && $stable(out_r), "result changed")

endmodule

// ----- rtl/p8isd_framer.sv -----
// Byte framer: tracks the position within an instruction and the byte address.
// Depends on p8isd_pkg for the frame type and the unary opcode test.
module p8isd_framer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic [7:0]        byte_value,
  input  logic              last_byte,
  output p8isd_pkg::frame_t frame
);
  import p8isd_pkg::*;

  typedef enum logic [1:0] {
    POS_OPCODE  = 2'd0,
    POS_OPND_HI = 2'd1,
    POS_OPND_LO = 2'd2
  } pos_t;

  pos_t        pos_r, pos_nxt;
  logic [15:0] addr_cnt_r, addr_cnt_nxt;
  logic [7:0]  held_op_r, held_op_nxt;
  logic [15:0] held_start_r, held_start_nxt;
  logic [7:0]  held_hi_r, held_hi_nxt;

  always_comb begin
    pos_nxt        = pos_r;
    addr_cnt_nxt   = addr_cnt_r + 16'd1;
    held_op_nxt    = held_op_r;
    held_start_nxt = held_start_r;
    held_hi_nxt    = held_hi_r;
    frame          = '0;
    unique case (pos_r)
      POS_OPND_HI: begin
        held_hi_nxt = byte_value;
        if (last_byte) begin
          frame = '{emit: 1'b1, addr: held_start_r, op: held_op_r,
                    spec: 16'd0, truncated: 1'b1};
        end else begin
          pos_nxt = POS_OPND_LO;
        end
      end
      POS_OPND_LO: begin
        frame = '{emit: 1'b1, addr: held_start_r, op: held_op_r,
                  spec: {held_hi_r, byte_value}, truncated: 1'b0};
        pos_nxt = POS_OPCODE;
      end
      default: begin
        held_op_nxt    = byte_value;
        held_start_nxt = addr_cnt_r;
        if (op_is_unary(byte_value)) begin
          frame = '{emit: 1'b1, addr: addr_cnt_r, op: byte_value,
                    spec: 16'd0, truncated: 1'b0};
          pos_nxt = POS_OPCODE;
        end else if (last_byte) begin
          frame = '{emit: 1'b1, addr: addr_cnt_r, op: byte_value,
                    spec: 16'd0, truncated: 1'b1};
          pos_nxt = POS_OPCODE;
        end else begin
          pos_nxt = POS_OPND_HI;
        end
      end
    endcase
    if (last_byte) begin
      pos_nxt      = POS_OPCODE;
      addr_cnt_nxt = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= POS_OPCODE;
      addr_cnt_r   <= 16'd0;
      held_op_r    <= 8'd0;
      held_start_r <= 16'd0;
      held_hi_r    <= 8'd0;
    end else if (advance) begin
      pos_r        <= pos_nxt;
      addr_cnt_r   <= addr_cnt_nxt;
      held_op_r    <= held_op_nxt;
      held_start_r <= held_start_nxt;
      held_hi_r    <= held_hi_nxt;
    end
  end

endmodule

// ----- rtl/p8isd_decode.sv -----
// Opcode field decoder: mnemonic number, register bit and addressing mode.
// Depends on p8isd_pkg for the frame and result types and opcode boundaries.
module p8isd_decode (
  input  p8isd_pkg::frame_t  frame,
  output p8isd_pkg::result_t result
);
  import p8isd_pkg::*;

  logic [7:0] op;
  logic [7:0] d;
  logic [5:0] mn;
  logic       un;
  logic       reg_sel;
  logic [2:0] mode;
  logic       onebit;

  assign op = frame.op;
  assign un = op_is_unary(op);

  always_comb begin
    d  = '0;
    mn = '0;
    if (op < OP_BR) begin
      mn = op[5:0];
    end else if (op < OP_NOTA) begin
      d  = op - OP_BR;
      mn = MN_BR + {1'b0, d[5:1]};
    end else if (op < OP_NOP0) begin
      d  = op - OP_NOTA;
      mn = MN_NOTA + d[5:0];
    end else if (op < OP_NOP) begin
      d  = op - OP_NOP0;
      mn = MN_NOP0 + d[5:0];
    end else if (op < OP_CHARI) begin
      d  = op - OP_NOP;
      mn = MN_NOP + {3'b0, d[5:3]};
    end else if (op < OP_RET0) begin
      d  = op - OP_CHARI;
      mn = MN_CHARI + {3'b0, d[5:3]};
    end else if (op < OP_ADDSP) begin
      d  = op - OP_RET0;
      mn = MN_RET0 + d[5:0];
    end else if (op < OP_ADDA) begin
      d  = op - OP_ADDSP;
      mn = MN_ADDSP + {3'b0, d[5:3]};
    end else begin
      d  = op - OP_ADDA;
      mn = MN_ADDA + {1'b0, d[7:3]};
    end
  end

  always_comb begin
    reg_sel = 1'b0;
    mode    = 3'd0;
    onebit  = 1'b0;
    if (op >= OP_NOTA && op < OP_NOP0) begin
      reg_sel = op[0];
    end else if (op >= OP_BR && op < OP_NOTA) begin
      mode   = {2'b0, op[0]};
      onebit = 1'b1;
    end else if (!un) begin
      mode    = op[2:0];
      reg_sel = (op >= OP_ADDA) ? op[3] : 1'b0;
    end
  end

  always_comb begin
    result.inst_address    = frame.addr;
    result.opcode          = op;
    result.mnemonic_code   = mn;
    result.register_select = reg_sel;
    result.addressing_mode = mode;
    result.one_bit_mode    = onebit;
    result.operand_spec    = (un || frame.truncated) ? 16'd0 : frame.spec;
    result.is_unary        = un;
    result.status          = frame.truncated;
  end

endmodule
